/* hdl/xxh32hc_pkg.sv */
// constants and types for the xxh32 short header checksum pipeline
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps

package xxh32hc_pkg;

    localparam int C_LOW_W  = 64;
    localparam int C_HIGH_W = 56;
    localparam int C_CNT_W  = 5;
    localparam int C_HASH_W = 32;
    localparam int C_CHK_W  = 8;
    localparam int C_SLOTS  = 6;

    localparam logic [31:0] C_PRIME_A = 32'h9E3779B1;
    localparam logic [31:0] C_PRIME_B = 32'h85EBCA77;
    localparam logic [31:0] C_PRIME_C = 32'hC2B2AE3D;
    localparam logic [31:0] C_PRIME_D = 32'h27D4EB2F;
    localparam logic [31:0] C_PRIME_E = 32'h165667B1;

    localparam logic [C_CNT_W-1:0] C_MIN_LEN    = 5'd2;
    localparam logic [C_CNT_W-1:0] C_STRIPE_LEN = 5'd16;

    localparam logic C_STATUS_OK  = 1'b0;
    localparam logic C_STATUS_LEN = 1'b1;

    // per-slot round kind: 0 word round, 1 byte round
    localparam logic [C_SLOTS-1:0] C_SLOT_KIND = 6'b111000;

    typedef struct packed {
        logic                             valid;
        logic                             err;
        logic [31:0]                      acc;
        logic [C_SLOTS-1:0]               act;
        logic [C_SLOTS-1:0]               kind;
        logic [C_SLOTS-1:0][31:0]         prod;
    } t_pipe;

    typedef struct packed {
        logic                valid;
        logic                status;
        logic [C_HASH_W-1:0] hash;
        logic [C_CHK_W-1:0]  check;
    } t_res;

endpackage

/* hdl/xxh32hc_in_if.sv */
// input channel carrying one short message and its byte count
// depends on xxh32hc_pkg
`timescale 1ns / 1ps

interface xxh32hc_in_if;
    import xxh32hc_pkg::*;

    logic                valid;
    logic                ready;
    logic [C_LOW_W-1:0]  data_low;
    logic [C_HIGH_W-1:0] data_high;
    logic [C_CNT_W-1:0]  byte_count;

    modport source (output valid, output data_low, output data_high, output byte_count,
                    input ready);
    modport sink (input valid, input data_low, input data_high, input byte_count,
                  output ready);
endinterface

/* hdl/xxh32hc_out_if.sv */
// result channel carrying status, hash and header check byte
// depends on xxh32hc_pkg
`timescale 1ns / 1ps

interface xxh32hc_out_if;
    import xxh32hc_pkg::*;

    logic                valid;
    logic                ready;
    logic                status;
    logic [C_HASH_W-1:0] hash_value;
    logic [C_CHK_W-1:0]  check_byte;

    modport source (output valid, output status, output hash_value, output check_byte,
                    input ready);
    modport sink (input valid, input status, input hash_value, input check_byte,
                  output ready);
endinterface

/* hdl/xxh32hc_cfg_if.sv */
// configuration write channel for the seed register
// depends on xxh32hc_pkg
`timescale 1ns / 1ps

interface xxh32hc_cfg_if;
    import xxh32hc_pkg::*;

    logic                valid;
    logic                ready;
    logic [C_HASH_W-1:0] hash_seed;

    modport source (output valid, output hash_seed, input ready);
    modport sink (input valid, input hash_seed, output ready);
endinterface

/* hdl/xxh32hc_prep.sv */
// entry stage: length check, accumulator seed, lane products and slot enables
// depends on xxh32hc_pkg
`timescale 1ns / 1ps

module xxh32hc_prep (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic [xxh32hc_pkg::C_LOW_W-1:0]      i_data_low,
    input  logic [xxh32hc_pkg::C_HIGH_W-1:0]     i_data_high,
    input  logic [xxh32hc_pkg::C_CNT_W-1:0]      i_byte_count,
    input  logic [xxh32hc_pkg::C_HASH_W-1:0]     i_seed,
    output xxh32hc_pkg::t_pipe                   o_pipe
);
    import xxh32hc_pkg::*;

    logic [C_HIGH_W+C_LOW_W-1:0] w_msg;
    logic [1:0]                  w_nw;
    logic [1:0]                  w_nb;
    logic [3:0]                  w_idx [3];
    logic [7:0]                  w_byte [3];
    t_pipe                       n_pipe;
    t_pipe                       r_pipe;

    assign w_msg = {i_data_high, i_data_low};
    assign w_nw  = i_byte_count[3:2];
    assign w_nb  = i_byte_count[1:0];

    always_comb begin
        n_pipe       = '0;
        n_pipe.valid = i_valid;
        n_pipe.err   = (i_byte_count < C_MIN_LEN) || (i_byte_count >= C_STRIPE_LEN);
        n_pipe.acc   = i_seed + C_PRIME_E + {27'd0, i_byte_count};
        n_pipe.kind  = C_SLOT_KIND;
        for (int k = 0; k < 3; k++) begin
            // full words sit at fixed byte offsets 0, 4, 8
            n_pipe.prod[k] = w_msg[32*k +: 32] * C_PRIME_C;
            n_pipe.act[k]  = !n_pipe.err && (w_nw > 2'(k));
        end
        for (int m = 0; m < 3; m++) begin
            // tail bytes start right after the last full word
            w_idx[m]         = {w_nw, 2'b00} + 4'(m);
            w_byte[m]        = w_msg[{w_idx[m], 3'b000} +: 8];
            n_pipe.prod[3+m] = {24'd0, w_byte[m]} * C_PRIME_E;
            n_pipe.act[3+m]  = !n_pipe.err && (w_nb > 2'(m));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe.valid <= 1'b0;
        end else if (i_en) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_pipe = r_pipe;
endmodule

/* hdl/xxh32hc_round.sv */
// one round slot: accumulate then rotate and multiply, two register stages
// depends on xxh32hc_pkg
`timescale 1ns / 1ps

module xxh32hc_round (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  xxh32hc_pkg::t_pipe i_pipe,
    output xxh32hc_pkg::t_pipe o_pipe
);
    import xxh32hc_pkg::*;

    t_pipe       n_add;
    t_pipe       r_add;
    t_pipe       n_mul;
    t_pipe       r_mul;
    logic [31:0] w_rot;
    logic [31:0] w_k;

    always_comb begin
        n_add = i_pipe;
        if (i_pipe.act[0]) begin
            n_add.acc = i_pipe.acc + i_pipe.prod[0];
        end
    end

    always_comb begin
        // byte rounds rotate by 11, word rounds by 17
        if (r_add.kind[0]) begin
            w_rot = {r_add.acc[20:0], r_add.acc[31:21]};
            w_k   = C_PRIME_A;
        end else begin
            w_rot = {r_add.acc[14:0], r_add.acc[31:15]};
            w_k   = C_PRIME_D;
        end
        n_mul      = r_add;
        n_mul.act  = {1'b0, r_add.act[C_SLOTS-1:1]};
        n_mul.kind = {1'b0, r_add.kind[C_SLOTS-1:1]};
        n_mul.prod = {32'd0, r_add.prod[C_SLOTS-1:1]};
        if (r_add.act[0]) begin
            n_mul.acc = w_rot * w_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add.valid <= 1'b0;
            r_mul.valid <= 1'b0;
        end else if (i_en) begin
            r_add <= n_add;
            r_mul <= n_mul;
        end
    end

    assign o_pipe = r_mul;
endmodule

/* hdl/xxh32hc_mix.sv */
// avalanche mix in three stages, the last of them the final result register
// depends on xxh32hc_pkg
`timescale 1ns / 1ps

module xxh32hc_mix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  xxh32hc_pkg::t_pipe i_pipe,
    output xxh32hc_pkg::t_res  o_res
);
    import xxh32hc_pkg::*;

    logic        r_v1;
    logic        r_e1;
    logic [31:0] r_h1;
    logic        r_v2;
    logic        r_e2;
    logic [31:0] r_h2;
    logic [31:0] n_h1;
    logic [31:0] n_h2;
    logic [31:0] w_h3;
    t_res        n_res;
    t_res        r_res;

    assign n_h1 = (i_pipe.acc ^ (i_pipe.acc >> 15)) * C_PRIME_B;
    assign n_h2 = (r_h1 ^ (r_h1 >> 13)) * C_PRIME_C;
    assign w_h3 = r_h2 ^ (r_h2 >> 16);

    always_comb begin
        n_res.valid = r_v2;
        if (r_e2) begin
            n_res.status = C_STATUS_LEN;
            n_res.hash   = '0;
            n_res.check  = '0;
        end else begin
            n_res.status = C_STATUS_OK;
            n_res.hash   = w_h3;
            n_res.check  = w_h3[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_res.valid <= 1'b0;
        end else if (i_en) begin
            r_v1  <= i_pipe.valid;
            r_e1  <= i_pipe.err;
            r_h1  <= n_h1;
            r_v2  <= r_v1;
            r_e2  <= r_e1;
            r_h2  <= n_h2;
            r_res <= n_res;
        end
    end

    assign o_res = r_res;
endmodule

/* hdl/xxh32hc_top.sv */
// top level of the xxh32 short header checksum block: from input beat to result beat
// the pipe has 1 entry stage, 6 round slots of 2 stages and 3 mix stages
// throughput one beat per cycle; the whole pipe holds while the result beat waits
// synchronous active-low reset clears all valid bits and sets the seed to zero
// depends on xxh32hc_pkg, the three channel interfaces, prep, round and mix
`timescale 1ns / 1ps

module xxhash32_short_header_checksum_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    xxh32hc_in_if.sink           i_in,
    xxh32hc_out_if.source        o_out,
    xxh32hc_cfg_if.sink          i_cfg
);
    import xxh32hc_pkg::*;

    logic [C_HASH_W-1:0] r_hash_seed;
    logic                w_en;
    t_pipe               w_stage [C_SLOTS+1];
    t_res                w_res;

    // seed register, always writable
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_seed <= '0;
        end else if (i_cfg.valid) begin
            r_hash_seed <= i_cfg.hash_seed;
        end
    end

    // one global advance: the pipe moves unless a finished beat is still unclaimed
    assign w_en       = !w_res.valid || o_out.ready;
    assign i_in.ready = w_en;

    // entry: length check, initial accumulator, all lane products in parallel
    xxh32hc_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (i_in.valid),
        .i_data_low   (i_in.data_low),
        .i_data_high  (i_in.data_high),
        .i_byte_count (i_in.byte_count),
        .i_seed       (r_hash_seed),
        .o_pipe       (w_stage[0])
    );

    // three word slots then three byte slots; idle slots pass the accumulator on
    for (genvar g_k = 0; g_k < C_SLOTS; g_k++) begin : g_round
        xxh32hc_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_pipe  (w_stage[g_k]),
            .o_pipe  (w_stage[g_k+1])
        );
    end

    // avalanche and result register; a bad length zeroes the hash fields
    xxh32hc_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_pipe  (w_stage[C_SLOTS]),
        .o_res   (w_res)
    );

    assign o_out.valid      = w_res.valid;
    assign o_out.status     = w_res.status;
    assign o_out.hash_value = w_res.hash;
    assign o_out.check_byte = w_res.check;

`ifndef SYNTHESIS
    // an error beat carries zero hash fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == C_STATUS_LEN)) |->
        ((o_out.hash_value == '0) && (o_out.check_byte == '0)))
        else $error("error beat with nonzero hash");

    // check byte is always the second byte of the hash
    a_check_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.check_byte == o_out.hash_value[15:8]))
        else $error("check byte does not match hash");

    // a bad length is flagged in the entry stage on the next edge
    a_len_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready &&
         ((i_in.byte_count < C_MIN_LEN) || (i_in.byte_count >= C_STRIPE_LEN)))
        |=> (w_stage[0].valid && w_stage[0].err))
        else $error("bad length not flagged");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");
`endif
endmodule

/* tb/xxhash32_short_header_checksum_top_tb.sv */
// self-checking testbench for the xxh32 short header checksum block
// depends on xxh32hc_pkg, the in, out and cfg channel interfaces and the block top
`timescale 1ns / 1ps

module xxhash32_short_header_checksum_top_tb;
    import xxh32hc_pkg::*;

    // xxh32 primes, kept apart from the package so a bad constant there shows up
    localparam logic [31:0] PRIME_1 = 32'h9E3779B1;
    localparam logic [31:0] PRIME_2 = 32'h85EBCA77;
    localparam logic [31:0] PRIME_3 = 32'hC2B2AE3D;
    localparam logic [31:0] PRIME_4 = 32'h27D4EB2F;
    localparam logic [31:0] PRIME_5 = 32'h165667B1;
    localparam int LEN_MIN    = 2;
    localparam int LEN_STRIPE = 16;

    // leave margin for the pipe to drain before touching the seed
    localparam int DRAIN_CYCLES  = 24;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int NUM_DIRECTED  = 22;
    localparam int NUM_PHASES    = 6;
    localparam int MSGS_PER_PHASE = 300;

    typedef struct packed {
        logic                status;
        logic [C_HASH_W-1:0] hash;
        logic [C_CHK_W-1:0]  check;
    } t_hash_result;

    typedef struct packed {
        logic [C_LOW_W-1:0]  lo;
        logic [C_HIGH_W-1:0] hi;
        logic [C_CNT_W-1:0]  cnt;
        logic                fixed;
        t_hash_result        res;
    } t_msg_row;

    localparam t_hash_result NO_RES  = '0;
    localparam t_hash_result LEN_ERR = '{status: C_STATUS_LEN, hash: 32'h0, check: 8'h0};

    localparam logic [63:0] ONES_LO = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [55:0] ONES_HI = 56'hFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SEQ_LO  = 64'h0706_0504_0302_0100;
    localparam logic [55:0] SEQ_HI  = 56'h0E_0D0C_0B0A_0908;

    logic i_clk;
    logic i_rst_n;

    xxh32hc_in_if  in_bus ();
    xxh32hc_out_if out_bus ();
    xxh32hc_cfg_if cfg_bus ();

    xxhash32_short_header_checksum_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    t_hash_result pending_hashes [$];
    t_hash_result oldest_hash;
    logic [31:0]  seed_shadow;
    logic [31:0]  phase_seed [NUM_PHASES];
    int           gap_pct;
    int           stall_pct;
    int           stall_left;
    int           err_cnt;
    int           cycle_cnt;

    // directed messages: length errors carry a typed result, the rest go to the predictor
    t_msg_row directed_rows [NUM_DIRECTED] = '{
        '{64'h0,   56'h0,   5'd0,  1'b1, LEN_ERR},   // empty message
        '{ONES_LO, ONES_HI, 5'd1,  1'b1, LEN_ERR},   // single byte
        '{SEQ_LO,  SEQ_HI,  5'd16, 1'b1, LEN_ERR},   // one full stripe
        '{ONES_LO, ONES_HI, 5'd31, 1'b1, LEN_ERR},   // largest count
        '{SEQ_LO,  SEQ_HI,  5'd24, 1'b1, LEN_ERR},
        '{64'h0,   56'h0,   5'd2,  1'b0, NO_RES},    // shortest legal, byte rounds only
        '{ONES_LO, ONES_HI, 5'd2,  1'b0, NO_RES},
        '{SEQ_LO,  SEQ_HI,  5'd3,  1'b0, NO_RES},
        '{SEQ_LO,  SEQ_HI,  5'd4,  1'b0, NO_RES},    // one word, no tail
        '{SEQ_LO,  SEQ_HI,  5'd5,  1'b0, NO_RES},
        '{SEQ_LO,  SEQ_HI,  5'd7,  1'b0, NO_RES},
        '{SEQ_LO,  SEQ_HI,  5'd8,  1'b0, NO_RES},    // word crosses into data_high next
        '{SEQ_LO,  SEQ_HI,  5'd9,  1'b0, NO_RES},
        '{SEQ_LO,  SEQ_HI,  5'd12, 1'b0, NO_RES},    // three words, no tail
        '{SEQ_LO,  SEQ_HI,  5'd13, 1'b0, NO_RES},
        '{SEQ_LO,  SEQ_HI,  5'd15, 1'b0, NO_RES},    // longest legal
        '{ONES_LO, ONES_HI, 5'd15, 1'b0, NO_RES},
        '{64'h0,   56'h0,   5'd15, 1'b0, NO_RES},
        // bytes past the length must not reach the hash
        '{64'h0000_0000_0000_3412, 56'h0,              5'd2,  1'b0, NO_RES},
        '{64'hA5A5_A5A5_A5A5_3412, 56'h5A_5A5A_5A5A_5A5A, 5'd2,  1'b0, NO_RES},
        '{SEQ_LO, 56'h00_0000_0B0A_0908,             5'd12, 1'b0, NO_RES},
        '{SEQ_LO, 56'hFF_FFFF_0B0A_0908,             5'd12, 1'b0, NO_RES}
    };

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int amt);
        return (x << amt) | (x >> (32 - amt));
    endfunction

    // xxh32 for messages shorter than one stripe, plus the header check byte
    function automatic t_hash_result xxh32_short_hash(input logic [63:0] lo,
                                                      input logic [55:0] hi,
                                                      input logic [4:0]  cnt,
                                                      input logic [31:0] seed);
        logic [119:0] msg;
        logic [31:0]  acc;
        logic [31:0]  word;
        int           len;
        int           pos;
        t_hash_result res;
        res = LEN_ERR;
        len = cnt;
        if (len < LEN_MIN || len >= LEN_STRIPE) begin
            return res;
        end
        msg = {hi, lo};
        acc = seed + PRIME_5 + 32'(len);
        pos = 0;
        while (len - pos >= 4) begin
            word = msg[8*pos +: 32];
            acc  = acc + word * PRIME_3;
            acc  = rotl32(acc, 17) * PRIME_4;
            pos  = pos + 4;
        end
        while (pos < len) begin
            acc = acc + {24'h0, msg[8*pos +: 8]} * PRIME_5;
            acc = rotl32(acc, 11) * PRIME_1;
            pos = pos + 1;
        end
        // avalanche
        acc = acc ^ (acc >> 15);
        acc = acc * PRIME_2;
        acc = acc ^ (acc >> 13);
        acc = acc * PRIME_3;
        acc = acc ^ (acc >> 16);
        res.status = C_STATUS_OK;
        res.hash   = acc;
        res.check  = acc[15:8];
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        $display("%0t ns: %s mismatch, expected %h got %h", $time, what, want, got);
        err_cnt++;
    endtask

    // drive one message beat, starting and ending at a falling edge
    task automatic push_message(input logic [63:0] lo, input logic [55:0] hi,
                                input logic [4:0] cnt, input logic fixed,
                                input t_hash_result fixed_res);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            in_bus.valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        in_bus.data_low   = lo;
        in_bus.data_high  = hi;
        in_bus.byte_count = cnt;
        in_bus.valid      = 1'b1;
        do @(posedge i_clk); while (!in_bus.ready);
        pending_hashes.push_back(fixed ? fixed_res
                                       : xxh32_short_hash(lo, hi, cnt, seed_shadow));
        @(negedge i_clk);
    endtask

    // seed changes only with the pipe empty
    task automatic write_seed(input logic [31:0] seed);
        in_bus.valid = 1'b0;
        while (pending_hashes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        cfg_bus.hash_seed = seed;
        cfg_bus.valid     = 1'b1;
        do @(posedge i_clk); while (!cfg_bus.ready);
        seed_shadow = seed;
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    // mostly legal lengths, with a share of out-of-range counts
    function automatic logic [4:0] pick_count();
        if ($urandom_range(0, 99) < 85) begin
            return 5'($urandom_range(LEN_MIN, LEN_STRIPE - 1));
        end
        return 5'($urandom_range(0, 31));
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // result side back-pressure: stall bursts of random length
    always @(negedge i_clk) begin
        if (!i_rst_n || stall_pct == 0) begin
            out_bus.ready <= 1'b1;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            out_bus.ready <= 1'b0;
            stall_left    <= $urandom_range(1, 15) - 1;
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    // result beat checker, oldest expectation first
    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_hashes.size() == 0) begin
                flag_mismatch("unexpected result beat", 32'h0, out_bus.hash_value);
            end else begin
                oldest_hash = pending_hashes.pop_front();
                if (out_bus.status !== oldest_hash.status) begin
                    flag_mismatch("status", 32'(oldest_hash.status), 32'(out_bus.status));
                end
                if (out_bus.hash_value !== oldest_hash.hash) begin
                    flag_mismatch("hash_value", oldest_hash.hash, out_bus.hash_value);
                end
                if (out_bus.check_byte !== oldest_hash.check) begin
                    flag_mismatch("check_byte", 32'(oldest_hash.check),
                                  32'(out_bus.check_byte));
                end
            end
        end
    end

    initial begin
        err_cnt           = 0;
        cycle_cnt         = 0;
        stall_left        = 0;
        seed_shadow       = 32'h0;
        i_rst_n           = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.data_low   = '0;
        in_bus.data_high  = '0;
        in_bus.byte_count = '0;
        out_bus.ready     = 1'b1;
        cfg_bus.valid     = 1'b0;
        cfg_bus.hash_seed = '0;
        gap_pct           = 20;
        stall_pct         = 20;

        // per-phase seeds, extremes first
        phase_seed[0] = 32'hFFFF_FFFF;
        phase_seed[1] = 32'h0000_0000;
        phase_seed[2] = $urandom;
        phase_seed[3] = 32'h8000_0001;
        phase_seed[4] = $urandom;
        phase_seed[5] = $urandom;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed messages under the reset seed
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            push_message(directed_rows[i].lo, directed_rows[i].hi, directed_rows[i].cnt,
                         directed_rows[i].fixed, directed_rows[i].res);
        end

        // random phases, each with its own seed and idling mix; the last runs flat out
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_seed(phase_seed[ph]);
            case (ph)
                0: begin gap_pct = 30; stall_pct = 30; end
                1: begin gap_pct = 10; stall_pct = 50; end
                2: begin gap_pct = 50; stall_pct = 10; end
                3: begin gap_pct = 0;  stall_pct = 30; end
                4: begin gap_pct = 30; stall_pct = 0;  end
                default: begin gap_pct = 0; stall_pct = 0; end
            endcase
            for (int n = 0; n < MSGS_PER_PHASE; n++) begin
                push_message({$urandom, $urandom}, 56'({$urandom, $urandom}),
                             pick_count(), 1'b0, NO_RES);
            end
        end

        in_bus.valid = 1'b0;
        while (pending_hashes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
